[rtl/core/bbpc_pkg.sv]
// Shared constants, codes and the token type for the breakpoint pass counter.
`timescale 1ns / 1ps

package bbpc_pkg;

  // Table depth: one cell per breakpoint entry
  localparam int ENTRIES = 16;

  localparam int OP_W     = 3;
  localparam int ADDR_W   = 16;
  localparam int BANK_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 3;

  // Addresses above this are fixed memory: a check's bank is forced to zero
  localparam logic [ADDR_W-1:0] BANKED_TOP = 16'h7FFF;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CHECK  = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_CHANGE = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_TOGGLE = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_BANK = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Request token that walks the chain, one cell per cycle
  typedef struct packed {
    logic               active;
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  address;
    logic [BANK_W-1:0]  key_bank;
    logic [COUNT_W-1:0] hit_count;
    logic               enable_flag;
    logic               bp_on;
    logic               bad;
    logic               found;
    logic               claimed;
    logic               hit;
  } token_t;

endpackage

[rtl/core/bbpc_req_if.sv]
// Request channel: valid/ready with the request payload.
`timescale 1ns / 1ps

interface bbpc_req_if;
  import bbpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ADDR_W-1:0]  address;
  logic [BANK_W-1:0]  bank;
  logic [COUNT_W-1:0] hit_count;
  logic               enable_flag;

  modport source (output valid, op, address, bank, hit_count, enable_flag, input ready);
  modport sink   (input valid, op, address, bank, hit_count, enable_flag, output ready);
endinterface

[rtl/core/bbpc_rsp_if.sv]
// Response channel: valid/ready with hit flag and status.
`timescale 1ns / 1ps

interface bbpc_rsp_if;
  import bbpc_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [STATUS_W-1:0] status;

  modport source (output valid, hit, status, input ready);
  modport sink   (input valid, hit, status, output ready);
endinterface

[rtl/core/bbpc_cell.sv]
// One breakpoint entry; acts on the passing token and hands it on.
`timescale 1ns / 1ps

module bbpc_cell (
  input  logic            clk,
  input  logic            rst,
  input  bbpc_pkg::token_t tok_in,
  input  logic            commit,
  input  logic            resolve,
  output bbpc_pkg::token_t tok_out,
  output logic            claim
);
  import bbpc_pkg::*;

  logic               valid;
  logic [ADDR_W-1:0]  address;
  logic [BANK_W-1:0]  bank;
  logic [COUNT_W-1:0] passes;
  logic [COUNT_W-1:0] required;
  logic               enabled;

  logic               match;
  logic               live;
  logic [COUNT_W:0]   passes_inc;
  logic               reached;
  token_t             tok_next;

  // Key compare and counter step
  assign live       = tok_in.active && !tok_in.bad;
  assign match      = valid && (address == tok_in.address) && (bank == tok_in.key_bank);
  assign passes_inc = {1'b0, passes} + {{COUNT_W{1'b0}}, 1'b1};
  assign reached    = passes_inc >= {1'b0, required};

  // Token update
  always_comb begin
    tok_next = tok_in;
    if (live && match && (tok_in.op != OP_CHECK)) begin
      tok_next.found = 1'b1;
    end
    if (live && (tok_in.op == OP_CHECK) && tok_in.bp_on && match && enabled && reached) begin
      tok_next.hit = 1'b1;
    end
    if (live && (tok_in.op == OP_SET) && !valid && !tok_in.claimed) begin
      tok_next.claimed = 1'b1;
    end
  end

  // Token register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Valid bit and tentative claim; a claim commits when the token leaves the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      claim <= 1'b0;
    end else begin
      if (resolve && claim) begin
        valid <= commit;
        claim <= 1'b0;
      end else if (live && (tok_in.op == OP_SET) && !valid && !tok_in.claimed) begin
        claim <= 1'b1;
      end else if (live && (tok_in.op == OP_DELETE) && match) begin
        valid <= 1'b0;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (live) begin
      unique case (tok_in.op)
        OP_CHECK: begin
          if (tok_in.bp_on && match && enabled) begin
            passes <= reached ? '0 : passes_inc[COUNT_W-1:0];
          end
        end
        OP_SET: begin
          if (!valid && !tok_in.claimed) begin
            address  <= tok_in.address;
            bank     <= tok_in.key_bank;
            passes   <= '0;
            required <= tok_in.hit_count;
            enabled  <= 1'b1;
          end
        end
        OP_CHANGE: begin
          if (match) begin
            required <= tok_in.hit_count;
          end
        end
        OP_TOGGLE: begin
          if (match) begin
            enabled <= tok_in.enable_flag;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/banked_breakpoint_pass_counter.sv]
// Top level: breakpoint table as a chain of entry cells, with result staging.
`timescale 1ns / 1ps

// A request walks the chain of ENTRIES cells one cell per clock; each cell
// compares its own entry against the request and counts, edits or claims
// itself. When the request leaves the last cell its result goes into a
// holding register and then the output register, and the next request is
// taken once the previous result reaches the output register, even if that
// result is still waiting to be taken. A set claims the lowest free cell on
// the way and the claim is confirmed when the request leaves the chain
// without having met a duplicate. bp_on resets to 1 and should be written
// only with no request in flight.
module banked_breakpoint_pass_counter (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  bbpc_req_if.sink       req,
  bbpc_rsp_if.source     rsp
);
  import bbpc_pkg::*;

  token_t                tok [ENTRIES+1];
  logic [ENTRIES-1:0]    claims;
  token_t                tail;
  logic                  bp_on;
  logic                  busy;
  logic                  hold_valid;
  logic                  hold_hit;
  logic [STATUS_W-1:0]   hold_status;
  logic                  commit;
  logic                  resolve;
  logic [STATUS_W-1:0]   status_next;
  logic                  take;
  logic                  move;

  assign take      = req.valid && req.ready;
  assign req.ready = !busy;

  // Global enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      bp_on <= 1'b1;
    end else if (cfg_we) begin
      bp_on <= cfg_wdata;
    end
  end

  // Build the entry token from the request; only table edits can have a bad bank
  always_comb begin
    tok[0]             = '0;
    tok[0].active      = take;
    tok[0].op          = req.op;
    tok[0].address     = req.address;
    tok[0].hit_count   = req.hit_count;
    tok[0].enable_flag = req.enable_flag;
    tok[0].bp_on       = bp_on;
    tok[0].key_bank    = ((req.op == OP_CHECK) && (req.address > BANKED_TOP)) ?
                         '0 : req.bank;
    tok[0].bad         = (req.op != OP_CHECK) && (req.op <= OP_TOGGLE) &&
                         (req.bank != '0) && (req.address > BANKED_TOP);
  end

  // Cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bbpc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .commit  (commit),
      .resolve (resolve),
      .tok_out (tok[i+1]),
      .claim   (claims[i])
    );
  end

  assign tail    = tok[ENTRIES];
  assign resolve = tail.active;
  assign commit  = tail.active && (tail.op == OP_SET) && !tail.bad &&
                   !tail.found && tail.claimed;

  // Status from the token leaving the chain
  always_comb begin
    status_next = ST_OK;
    if (tail.bad) begin
      status_next = ST_BAD_BANK;
    end else begin
      unique case (tail.op)
        OP_SET: begin
          if (tail.found) begin
            status_next = ST_PRESENT;
          end else if (!tail.claimed) begin
            status_next = ST_FULL;
          end
        end
        OP_CHANGE, OP_DELETE, OP_TOGGLE: begin
          if (!tail.found) begin
            status_next = ST_ABSENT;
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  assign move = hold_valid && (!rsp.valid || rsp.ready);

  // Busy flag and result staging
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      hold_valid <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (tail.active) begin
        hold_valid <= 1'b1;
      end else if (move) begin
        hold_valid <= 1'b0;
      end
      if (move) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.active) begin
      hold_hit    <= tail.hit && (tail.op == OP_CHECK);
      hold_status <= status_next;
    end
    if (move) begin
      rsp.hit    <= hold_hit;
      rsp.status <= hold_status;
    end
  end

  // At most one cell holds an unconfirmed claim
  assert property (@(posedge clk) disable iff (rst) $countones(claims) <= 1)
    else $error("more than one pending claim");

  // A token leaves the chain only while a request is in flight
  assert property (@(posedge clk) disable iff (rst) tail.active |-> busy && !hold_valid)
    else $error("token left chain with no request in flight");

  // Claims are resolved when the token leaves the chain
  assert property (@(posedge clk) disable iff (rst) tail.active |=> claims == '0)
    else $error("claim survived request completion");

  // A staged result implies the block is still busy
  assert property (@(posedge clk) disable iff (rst) hold_valid |-> busy)
    else $error("staged result while idle");

endmodule

[verif/testbench.sv]
// Testbench for the banked breakpoint pass counter: table predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module testbench;
  import bbpc_pkg::*;

  localparam int KEYS         = 24;
  localparam int PHASE_ITEMS  = 315;
  localparam int DRAIN_CYCLES = ENTRIES + 6;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PRINT_CAP    = 50;

  // One expected result per accepted request
  typedef struct packed {
    logic                hit;
    logic [STATUS_W-1:0] status;
  } bp_result_t;

  // Scoreboard: holds its own copy of the breakpoint table and the queue of outcomes
  class bp_table_scoreboard;
    bit                 bp_on;
    bit                 ent_valid    [ENTRIES];
    logic [ADDR_W-1:0]  ent_addr     [ENTRIES];
    logic [BANK_W-1:0]  ent_bank     [ENTRIES];
    logic [COUNT_W-1:0] ent_passes   [ENTRIES];
    logic [COUNT_W-1:0] ent_required [ENTRIES];
    bit                 ent_enabled  [ENTRIES];
    bp_result_t         expected_outcomes[$];
    int unsigned        mismatches;

    function new();
      bp_on      = 1'b1;
      mismatches = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        ent_valid[i]    = 1'b0;
        ent_addr[i]     = '0;
        ent_bank[i]     = '0;
        ent_passes[i]   = '0;
        ent_required[i] = '0;
        ent_enabled[i]  = 1'b0;
      end
    endfunction

    function int find_key(logic [ADDR_W-1:0] a, logic [BANK_W-1:0] b);
      for (int i = 0; i < ENTRIES; i++)
        if (ent_valid[i] && ent_addr[i] == a && ent_bank[i] == b) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < ENTRIES; i++)
        if (!ent_valid[i]) return i;
      return -1;
    endfunction

    // Applies one request to the table copy and returns what the block should answer
    function bp_result_t predict_outcome(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                         logic [BANK_W-1:0] b, logic [COUNT_W-1:0] c,
                                         logic e);
      bp_result_t         r;
      int                 idx;
      int                 slot;
      logic [BANK_W-1:0]  cur;
      logic [COUNT_W:0]   nxt;
      r.hit    = 1'b0;
      r.status = ST_OK;
      case (op)
        OP_CHECK: begin
          // fixed memory above the banked window always counts as bank 0
          cur = (a > BANKED_TOP) ? '0 : b;
          if (bp_on) begin
            idx = find_key(a, cur);
            if (idx >= 0 && ent_enabled[idx]) begin
              nxt = {1'b0, ent_passes[idx]} + 1'b1;
              if (nxt >= {1'b0, ent_required[idx]}) begin
                ent_passes[idx] = '0;
                r.hit = 1'b1;
              end else begin
                ent_passes[idx] = nxt[COUNT_W-1:0];
              end
            end
          end
        end
        OP_SET, OP_CHANGE, OP_DELETE, OP_TOGGLE: begin
          if (b != '0 && a > BANKED_TOP) begin
            r.status = ST_BAD_BANK;
          end else begin
            idx = find_key(a, b);
            if (op == OP_SET) begin
              if (idx >= 0) begin
                r.status = ST_PRESENT;
              end else begin
                slot = find_free();
                if (slot < 0) begin
                  r.status = ST_FULL;
                end else begin
                  ent_valid[slot]    = 1'b1;
                  ent_addr[slot]     = a;
                  ent_bank[slot]     = b;
                  ent_passes[slot]   = '0;
                  ent_required[slot] = c;
                  ent_enabled[slot]  = 1'b1;
                end
              end
            end else if (idx < 0) begin
              r.status = ST_ABSENT;
            end else if (op == OP_CHANGE) begin
              ent_required[idx] = c;
            end else if (op == OP_DELETE) begin
              ent_valid[idx] = 1'b0;
            end else begin
              ent_enabled[idx] = e;
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                               logic [BANK_W-1:0] b, logic [COUNT_W-1:0] c, logic e);
      expected_outcomes.push_back(predict_outcome(op, a, b, c, e));
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_CAP) $display("%0t: ERROR %s", $realtime, msg);
      mismatches++;
    endtask

    task check_response(logic hit, logic [STATUS_W-1:0] status);
      bp_result_t want;
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("response with nothing outstanding: hit=%0b status=%0d",
                                  hit, status));
        return;
      end
      want = expected_outcomes.pop_front();
      if (hit !== want.hit)
        report_mismatch($sformatf("hit %0b, want %0b", hit, want.hit));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  bbpc_req_if req_ch ();
  bbpc_rsp_if rsp_ch ();

  banked_breakpoint_pass_counter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  bp_table_scoreboard sb = new();

  int unsigned       req_taken;
  int unsigned       idle_cycles;
  bit                steady;
  logic [ADDR_W-1:0] key_addr [KEYS];
  logic [BANK_W-1:0] key_bank [KEYS];

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Transfer monitor, checker and watchdog, all on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.op, req_ch.address, req_ch.bank, req_ch.hit_count,
                        req_ch.enable_flag);
        req_taken++;
      end
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.hit, rsp_ch.status);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Mostly short pauses, now and then a long one; none in a steady phase
  function automatic int unsigned pick_pause();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Response side back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold > 0) begin
        rsp_ch.ready = 1'b0;
        hold--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) hold = pick_pause();
      end
      @(negedge clk);
    end
  end

  // Drive one request from a falling edge until it is taken, then a random pause
  task automatic send_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                          logic [BANK_W-1:0] b, logic [COUNT_W-1:0] c, logic e);
    int unsigned want;
    int unsigned pause;
    want               = req_taken + 1;
    req_ch.op          = op;
    req_ch.address     = a;
    req_ch.bank        = b;
    req_ch.hit_count   = c;
    req_ch.enable_flag = e;
    req_ch.valid       = 1'b1;
    do @(negedge clk); while (req_taken != want);
    pause = pick_pause();
    if (pause > 0) begin
      req_ch.valid = 1'b0;
      repeat (pause) @(negedge clk);
    end
  endtask

  // Wait until every outcome is in and the chain has emptied
  task automatic drain();
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_bp_on(logic v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.bp_on  = v;
  endtask

  // Small counts so that hits come often; the odd wide or top value
  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return COUNT_W'($urandom_range(0, 4));
    if (r < 95) return COUNT_W'($urandom_range(0, 16'hFFFF));
    return 16'hFFFF;
  endfunction

  // Mostly operations on a small key set, with some raw noise
  task automatic send_random();
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  a;
    logic [BANK_W-1:0]  b;
    logic [COUNT_W-1:0] c;
    logic               e;
    int unsigned        pick;
    int unsigned        k;
    c    = pick_count();
    e    = ($urandom_range(0, 9) < 7);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      op = OP_W'($urandom_range(0, 7));
      a  = ADDR_W'($urandom_range(0, 16'hFFFF));
      b  = BANK_W'($urandom_range(0, 8'hFF));
      e  = 1'($urandom_range(0, 1));
    end else begin
      k    = $urandom_range(0, KEYS - 1);
      a    = key_addr[k];
      b    = key_bank[k];
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op = OP_CHECK;
        // bank is ignored above the banked window
        if (a > BANKED_TOP) b = BANK_W'($urandom_range(0, 8'hFF));
      end else if (pick < 67) begin
        op = OP_SET;
      end else if (pick < 77) begin
        op = OP_CHANGE;
      end else if (pick < 87) begin
        op = OP_DELETE;
      end else begin
        op = OP_TOGGLE;
      end
    end
    send_req(op, a, b, c, e);
  endtask

  // Main sequence
  initial begin
    logic on_plan [6];
    on_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_CHECK;
    req_ch.address     = '0;
    req_ch.bank        = '0;
    req_ch.hit_count   = '0;
    req_ch.enable_flag = 1'b0;
    req_taken          = 0;
    idle_cycles        = 0;
    steady             = 1'b0;

    // Key set: corner addresses first, then random banked and fixed ones
    key_addr[0] = 16'h0000; key_bank[0] = 8'h00;
    key_addr[1] = 16'h0000; key_bank[1] = 8'hFF;
    key_addr[2] = 16'h7FFF; key_bank[2] = 8'h00;
    key_addr[3] = 16'h7FFF; key_bank[3] = 8'h80;
    key_addr[4] = 16'h8000; key_bank[4] = 8'h00;
    key_addr[5] = 16'hFFFF; key_bank[5] = 8'h00;
    for (int i = 6; i < KEYS; i++) begin
      if (i % 2 == 0) begin
        key_addr[i] = ADDR_W'($urandom_range(0, 16'h7FFF));
        key_bank[i] = BANK_W'($urandom_range(0, 8'hFF));
      end else begin
        key_addr[i] = ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
        key_bank[i] = '0;
      end
    end

    repeat (3) @(negedge clk);
    rst = 1'b0;
    write_bp_on(1'b1);

    // Directed: zero required, duplicate, bad bank, bank folding, enable, lowered count
    send_req(OP_SET,    16'h0000, 8'h00, 16'd0,    1'b0);
    send_req(OP_CHECK,  16'h0000, 8'h00, 16'hFFFF, 1'b1);
    send_req(OP_SET,    16'h0000, 8'h00, 16'd3,    1'b0);
    send_req(OP_SET,    16'hFFFF, 8'hFF, 16'd2,    1'b1);
    send_req(OP_SET,    16'hFFFF, 8'h00, 16'd2,    1'b0);
    send_req(OP_CHECK,  16'hFFFF, 8'hFF, 16'h0000, 1'b0);
    send_req(OP_CHECK,  16'hFFFF, 8'hAB, 16'h0000, 1'b0);
    send_req(OP_CHANGE, 16'h1234, 8'h05, 16'd1,    1'b0);
    send_req(OP_DELETE, 16'h8000, 8'h01, 16'd0,    1'b0);
    send_req(OP_TOGGLE, 16'hFFFF, 8'h00, 16'd0,    1'b0);
    send_req(OP_CHECK,  16'hFFFF, 8'h00, 16'd0,    1'b0);
    send_req(OP_TOGGLE, 16'hFFFF, 8'h00, 16'd0,    1'b1);
    send_req(OP_SET,    16'h7FFF, 8'hFF, 16'hFFFF, 1'b0);
    send_req(OP_CHECK,  16'h7FFF, 8'hFF, 16'd0,    1'b0);
    send_req(OP_CHECK,  16'h7FFF, 8'hFF, 16'd0,    1'b0);
    send_req(OP_CHECK,  16'h7FFF, 8'hFF, 16'd0,    1'b0);
    send_req(OP_CHANGE, 16'h7FFF, 8'hFF, 16'd1,    1'b0);
    send_req(OP_CHECK,  16'h7FFF, 8'hFF, 16'd0,    1'b0);
    send_req(OP_DELETE, 16'h0000, 8'h00, 16'd0,    1'b0);
    send_req(OP_CHECK,  16'h0000, 8'h00, 16'd0,    1'b0);
    send_req(OP_DELETE, 16'h0000, 8'h00, 16'd0,    1'b0);
    // unused op codes
    send_req(3'd5, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
    send_req(3'd6, 16'h5A5A, 8'h5A, 16'hA5A5, 1'b0);
    send_req(3'd7, 16'h0000, 8'h00, 16'h0000, 1'b1);
    drain();

    // Random phases, switching the global enable between them
    for (int p = 0; p < 6; p++) begin
      write_bp_on(on_plan[p]);
      steady = (p == 3);
      repeat (PHASE_ITEMS) send_random();
      drain();
    end
    steady = 1'b0;

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
